>>> rtl/tlpq_pkg.sv
package tlpq_pkg;

    localparam int TAG_W      = 16;
    localparam int LEVEL_W    = 2;
    localparam int OCC_W      = 6;
    localparam int NUM_LEVELS = 3;

    typedef enum logic
    {
        OP_ENQUEUE = 1'b0,
        OP_DEQUEUE = 1'b1
    } op_t;

    localparam logic [LEVEL_W-1:0] LVL_GENERAL = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_MEDIUM  = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_SERIOUS = 2'd2;

    typedef struct packed
    {
        logic               operation;
        logic [LEVEL_W-1:0] level;
        logic [TAG_W-1:0]   tag;
    } in_item_t;

    typedef struct packed
    {
        logic               served_valid;
        logic [TAG_W-1:0]   served_tag;
        logic [LEVEL_W-1:0] served_level;
        logic               empty_flag;
        logic               full_flag;
        logic [OCC_W-1:0]   occupancy;
    } out_item_t;

    typedef struct packed
    {
        logic               served_valid;
        logic [LEVEL_W-1:0] served_level;
        logic               empty_flag;
        logic               full_flag;
        logic [OCC_W-1:0]   occupancy;
    } resp_t;

endpackage

>>> rtl/tlpq_store.sv
module tlpq_store
    import tlpq_pkg::*;
#(
    parameter int ENTRIES = 48,
    parameter int AW      = $clog2(ENTRIES)
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [TAG_W-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [TAG_W-1:0] rd_data
);

    logic [TAG_W-1:0] mem [ENTRIES];
    logic [TAG_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/tlpq_ctrl.sv
module tlpq_ctrl
    import tlpq_pkg::*;
#(
    parameter int LEVEL_DEPTH = 16,
    parameter int AW          = $clog2(NUM_LEVELS * LEVEL_DEPTH)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  in_item_t         req,
    output logic             wr_en,
    output logic [AW-1:0]    wr_addr,
    output logic [TAG_W-1:0] wr_data,
    output logic             rd_en,
    output logic [AW-1:0]    rd_addr,
    output resp_t            resp,
    output logic             done
);

    localparam int PW = $clog2(LEVEL_DEPTH);
    localparam int CW = $clog2(LEVEL_DEPTH + 1);
    localparam int SW = CW + 2;

    logic [PW-1:0]      head_reg   [NUM_LEVELS];
    logic [PW-1:0]      head_next  [NUM_LEVELS];
    logic [PW-1:0]      tail_reg   [NUM_LEVELS];
    logic [PW-1:0]      tail_next  [NUM_LEVELS];
    logic [CW-1:0]      count_reg  [NUM_LEVELS];
    logic [CW-1:0]      count_next [NUM_LEVELS];
    resp_t              resp_reg;
    resp_t              resp_next;
    logic               done_reg;
    logic               done_next;
    logic [LEVEL_W-1:0] enq_level;
    logic [LEVEL_W-1:0] pick;
    logic               pick_found;
    logic [SW-1:0]      total;

    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] slot);
        logic [PW-1:0] r;
        if (slot == PW'(LEVEL_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = slot + PW'(1);
        end
        return r;
    endfunction

    // out-of-range level folds into serious
    assign enq_level = (req.level >= LVL_SERIOUS) ? LVL_SERIOUS : req.level;

    always_comb
    begin
        pick_found = 1'b0;
        pick       = LVL_GENERAL;
        for (int l = NUM_LEVELS - 1; l >= 0; l--)
        begin
            if (!pick_found && count_reg[l] != '0)
            begin
                pick_found = 1'b1;
                pick       = LEVEL_W'(l);
            end
        end
    end

    always_comb
    begin
        wr_en     = 1'b0;
        wr_addr   = '0;
        wr_data   = req.tag;
        rd_en     = 1'b0;
        rd_addr   = '0;
        resp_next = '0;
        done_next = accept;
        for (int l = 0; l < NUM_LEVELS; l++)
        begin
            head_next[l]  = head_reg[l];
            tail_next[l]  = tail_reg[l];
            count_next[l] = count_reg[l];
        end
        if (accept)
        begin
            if (req.operation == OP_ENQUEUE)
            begin
                for (int l = 0; l < NUM_LEVELS; l++)
                begin
                    if (enq_level == LEVEL_W'(l))
                    begin
                        if (count_reg[l] == CW'(LEVEL_DEPTH))
                        begin
                            resp_next.full_flag = 1'b1;
                        end
                        else
                        begin
                            wr_en         = 1'b1;
                            wr_addr       = AW'(l * LEVEL_DEPTH) + AW'(tail_reg[l]);
                            tail_next[l]  = ring_next(tail_reg[l]);
                            count_next[l] = count_reg[l] + CW'(1);
                        end
                    end
                end
            end
            else if (!pick_found)
            begin
                resp_next.empty_flag = 1'b1;
            end
            else
            begin
                resp_next.served_valid = 1'b1;
                resp_next.served_level = pick;
                rd_en                  = 1'b1;
                for (int l = 0; l < NUM_LEVELS; l++)
                begin
                    if (pick == LEVEL_W'(l))
                    begin
                        rd_addr       = AW'(l * LEVEL_DEPTH) + AW'(head_reg[l]);
                        head_next[l]  = ring_next(head_reg[l]);
                        count_next[l] = count_reg[l] - CW'(1);
                    end
                end
            end
        end
        total = '0;
        for (int l = 0; l < NUM_LEVELS; l++)
        begin
            total = total + SW'(count_next[l]);
        end
        resp_next.occupancy = OCC_W'(total);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < NUM_LEVELS; l++)
            begin
                head_reg[l]  <= '0;
                tail_reg[l]  <= '0;
                count_reg[l] <= '0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            for (int l = 0; l < NUM_LEVELS; l++)
            begin
                head_reg[l]  <= head_next[l];
                tail_reg[l]  <= tail_next[l];
                count_reg[l] <= count_next[l];
            end
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            resp_reg <= resp_next;
        end
    end

    assign resp = resp_reg;
    assign done = done_reg;

endmodule

>>> rtl/three_level_priority_queue.sv
// channel   ports                     transfer condition
// command   start, busy, request      start high and busy low at the clock edge
// result    done, result              done high for one cycle, no back-pressure
//
// one command is taken every cycle; its result appears on the following cycle
// the result is registered: the served tag comes from the registered read port of the entry memory
// busy stays low, the ring pointers and counts update at the command edge
// reset clears pointers and counts; entry memory is not cleared
// results cannot be stalled by the receiver
module three_level_priority_queue
    import tlpq_pkg::*;
#(
    parameter int LEVEL_DEPTH = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_item_t  request,
    output logic      done,
    output out_item_t result
);

    localparam int ENTRIES = NUM_LEVELS * LEVEL_DEPTH;
    localparam int AW      = $clog2(ENTRIES);

    logic             accept;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [TAG_W-1:0] wr_data;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [TAG_W-1:0] rd_data;
    resp_t            resp;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    tlpq_ctrl #(
        .LEVEL_DEPTH (LEVEL_DEPTH),
        .AW          (AW)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .req     (request),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .resp    (resp),
        .done    (done)
    );

    tlpq_store #(
        .ENTRIES (ENTRIES),
        .AW      (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        result.served_valid = resp.served_valid;
        result.served_tag   = resp.served_valid ? rd_data : '0;
        result.served_level = resp.served_level;
        result.empty_flag   = resp.empty_flag;
        result.full_flag    = resp.full_flag;
        result.occupancy    = resp.occupancy;
    end

    a_done_follows_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        done == $past(start && !busy && rst_n))
        else $error("done does not follow a command transfer");

    a_full_only_on_enqueue: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.full_flag |-> $past(request.operation == OP_ENQUEUE))
        else $error("full flag on a dequeue");

    a_served_only_on_dequeue: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.served_valid || result.empty_flag)
            |-> $past(request.operation == OP_DEQUEUE))
        else $error("served or empty flag on an enqueue");

endmodule
